@@ sv/tail_drop_packet_buffer_assert.svh @@
// Assertion macros for the tail-drop packet buffer
`ifndef TAIL_DROP_PACKET_BUFFER_ASSERT_SVH
`define TAIL_DROP_PACKET_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
// check a condition at every clock edge outside reset
`define TDPB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// check that a trigger is followed by a condition in the next cycle
`define TDPB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define TDPB_ASSERT_ALWAYS(lbl, cond, msg)
`define TDPB_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

@@ sv/tdpb_pkg.sv @@
// Shared constants and types for the tail-drop packet buffer
`timescale 1ns / 1ps

package tdpb_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int TIME_BITS = 32;

  // field widths fixed by the interface
  localparam int ARR_W = 32;
  localparam int PROC_W = 16;
  localparam int CFG_W = 5;

  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int OCC_W = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W = OCC_W + 1;
  localparam int CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam int ADD_W = ((TIME_BITS > PROC_W) ? TIME_BITS : PROC_W) + 1;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FREE = 2'b10
  } tdpb_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pop;
    logic commit;
  } tdpb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_pop;
    logic out_blocked;
  } tdpb_status_t;

endpackage

@@ sv/tdpb_ctrl.sv @@
// Controller state machine: take one packet, free finished slots, then decide
`timescale 1ns / 1ps

module tdpb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tdpb_pkg::tdpb_status_t status,
  output tdpb_pkg::tdpb_cmd_t    cmd
);
  import tdpb_pkg::*;

  tdpb_state_t state;
  tdpb_state_t state_next;

  // hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // sequence the work of one packet
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_FREE;
        end
      end
      ST_FREE: begin
        if (status.can_pop) begin
          cmd.pop = 1'b1;
        end else if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/tdpb_datapath.sv @@
// Datapath: finish-time ring, occupancy, last finish, capacity and result register
`timescale 1ns / 1ps

module tdpb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tdpb_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic [tdpb_pkg::ARR_W-1:0]  arrival_time,
  input  logic [tdpb_pkg::PROC_W-1:0] proc_time,
  input  tdpb_pkg::tdpb_cmd_t         cmd,
  output tdpb_pkg::tdpb_status_t      status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        accepted,
  output logic [tdpb_pkg::ARR_W-1:0]  arrival_echo
);
  import tdpb_pkg::*;

  logic [CFG_W-1:0]     buffer_size;
  logic [ARR_W-1:0]     arr_raw;
  logic [PROC_W-1:0]    proc;
  logic [TIME_BITS-1:0] finish_ring [BUF_DEPTH];
  logic [IDX_W-1:0]     head_index;
  logic [OCC_W-1:0]     occupancy;
  logic [TIME_BITS-1:0] last_finish;

  logic [TIME_BITS-1:0] arr_t;
  logic [CAP_W-1:0]     cap;
  logic                 room;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail_index;
  logic [TIME_BITS-1:0] start_time;
  logic [ADD_W-1:0]     fin_sum;
  logic [TIME_BITS-1:0] fin;

  // hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= CFG_W'(BUF_DEPTH > 16 ? 16 : 16);
    end else if (cfg_wr_en) begin
      buffer_size <= cfg_wr_data;
    end
  end

  // capture the packet on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_raw <= arrival_time;
      proc <= proc_time;
    end
  end

  assign arr_t = TIME_BITS'(arr_raw);

  // oldest packet finished by the arrival time
  assign status.can_pop = (occupancy != '0) && (finish_ring[head_index] <= arr_t);
  assign status.out_blocked = out_valid && out_stall;

  // clamp capacity to the ring depth
  always_comb begin
    cap = CAP_W'(buffer_size);
    if (cap > CAP_W'(BUF_DEPTH)) begin
      cap = CAP_W'(BUF_DEPTH);
    end
  end

  assign room = CAP_W'(occupancy) < cap;

  // slot after the newest packet, wrapped to the ring
  always_comb begin
    tail_sum = SUM_W'(head_index) + SUM_W'(occupancy);
    if (tail_sum >= SUM_W'(BUF_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(BUF_DEPTH);
    end
    tail_index = tail_sum[IDX_W-1:0];
  end

  // finish time, saturating at the largest time
  assign start_time = (arr_t > last_finish) ? arr_t : last_finish;
  assign fin_sum = ADD_W'(start_time) + ADD_W'(proc);
  assign fin = (fin_sum > ADD_W'(TIME_MAX)) ? TIME_MAX : fin_sum[TIME_BITS-1:0];

  // write the ring on enqueue
  always_ff @(posedge clk) begin
    if (cmd.commit && room) begin
      finish_ring[tail_index] <= fin;
    end
  end

  // advance head and occupancy, track last finish
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      occupancy <= '0;
      last_finish <= '0;
    end else if (cmd.pop) begin
      head_index <= (head_index == IDX_W'(BUF_DEPTH - 1)) ? '0 : head_index + IDX_W'(1);
      occupancy <= occupancy - OCC_W'(1);
    end else if (cmd.commit && room) begin
      occupancy <= occupancy + OCC_W'(1);
      last_finish <= fin;
    end
  end

  // result register: load on decision, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted <= room;
      arrival_echo <= room ? arr_raw : '0;
    end
  end

endmodule

@@ sv/tail_drop_packet_buffer.sv @@
// Top level of the tail-drop packet buffer: controller and datapath
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------
//   in      | in_valid/in_stall  | arrival_time, proc_time
//   out     | out_valid/out_stall| accepted, arrival_echo
//   cfg     | cfg_wr_en          | cfg_wr_data (buffer_size)
//
// One packet at a time: each packet is taken, then one finished slot is freed per cycle
// while the single head-of-ring compare in the datapath passes, then the packet is decided.
// Freeing is amortised: each slot is freed once.
// Synchronous reset empties the buffer and sets the capacity to 16.
// A stalled result holds in the output register; the next packet is taken
// meanwhile and waits only at its decision for the register to empty.
`timescale 1ns / 1ps

`include "tail_drop_packet_buffer_assert.svh"

module tail_drop_packet_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tdpb_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tdpb_pkg::ARR_W-1:0]  arrival_time,
  input  logic [tdpb_pkg::PROC_W-1:0] proc_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        accepted,
  output logic [tdpb_pkg::ARR_W-1:0]  arrival_echo
);
  import tdpb_pkg::*;

  tdpb_cmd_t    cmd;
  tdpb_status_t status;

  tdpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tdpb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .arrival_time (arrival_time),
    .proc_time    (proc_time),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .arrival_echo (arrival_echo)
  );

  // a transfer in leaves the input closed until the decision
  `TDPB_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input open while busy")
  // a decision never overwrites a result still waiting
  `TDPB_ASSERT_ALWAYS(a_no_overwrite, !cmd.commit || !(out_valid && out_stall), "result overwritten")
  // freeing and deciding are exclusive
  `TDPB_ASSERT_ALWAYS(a_pop_or_commit, !(cmd.pop && cmd.commit), "pop and commit together")
  // a decision always produces a valid result next cycle
  `TDPB_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "decision without result")

endmodule

@@ dv/tail_drop_packet_buffer_tb.sv @@
// Testbench for the tail-drop packet buffer: random and directed packets against a scoreboard
`timescale 1ns / 1ps

module tail_drop_packet_buffer_tb;

  localparam int unsigned CLK_HALF_NS  = 5;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  typedef logic [tdpb_pkg::TIME_BITS-1:0] tick_t;

  // one expected outcome per arriving packet
  typedef struct {
    logic                      accepted;
    logic [tdpb_pkg::ARR_W-1:0] arrival_echo;
  } verdict_t;

  // Tracks buffer occupancy and finish times; predicts queue or drop per packet.
  class tail_drop_scoreboard;
    tick_t       finish_ring[tdpb_pkg::BUF_DEPTH];
    int unsigned head;
    int unsigned fill;
    tick_t       last_finish;
    logic [tdpb_pkg::CFG_W-1:0] capacity;
    verdict_t    verdicts[$];
    int unsigned errors;
    int unsigned n_queued;
    int unsigned n_dropped;

    function new();
      foreach (finish_ring[i]) finish_ring[i] = '0;
      head = 0;
      fill = 0;
      last_finish = '0;
      capacity = 5'd16;
      errors = 0;
      n_queued = 0;
      n_dropped = 0;
    endfunction

    function void set_capacity(logic [tdpb_pkg::CFG_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction

    // Free finished packets, then queue or drop the new one.
    function void note_packet(logic [tdpb_pkg::ARR_W-1:0] arrival,
                              logic [tdpb_pkg::PROC_W-1:0] proc);
      tick_t       now;
      tick_t       start;
      tick_t       fin;
      logic [tdpb_pkg::TIME_BITS:0] sum;
      int unsigned cap;
      verdict_t    v;
      now = tick_t'(arrival);
      cap = (capacity > tdpb_pkg::BUF_DEPTH) ? tdpb_pkg::BUF_DEPTH : capacity;
      // release everything finished by now, ties included
      while (fill > 0 && finish_ring[head] <= now) begin
        head = (head + 1) % tdpb_pkg::BUF_DEPTH;
        fill--;
      end
      if (fill >= cap) begin
        v.accepted = 1'b0;
        v.arrival_echo = '0;
      end else begin
        start = (now > last_finish) ? now : last_finish;
        sum = {1'b0, start} + proc;
        fin = sum[tdpb_pkg::TIME_BITS] ? tdpb_pkg::TIME_MAX : sum[tdpb_pkg::TIME_BITS-1:0];
        finish_ring[(head + fill) % tdpb_pkg::BUF_DEPTH] = fin;
        fill++;
        last_finish = fin;
        v.accepted = 1'b1;
        v.arrival_echo = arrival;
      end
      verdicts.insert(verdicts.size(), v);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(logic accepted, logic [tdpb_pkg::ARR_W-1:0] arrival_echo);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result with no packet outstanding: accepted=%0b arrival_echo=%0h",
               accepted, arrival_echo);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (accepted !== v.accepted) begin
        $error("accepted: expected %0b, got %0b", v.accepted, accepted);
        errors++;
      end
      if (arrival_echo !== v.arrival_echo) begin
        $error("arrival_echo: expected %0h, got %0h", v.arrival_echo, arrival_echo);
        errors++;
      end
      if (v.accepted) n_queued++;
      else n_dropped++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [tdpb_pkg::CFG_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [tdpb_pkg::ARR_W-1:0] arrival_time;
  logic [tdpb_pkg::PROC_W-1:0] proc_time;
  logic out_valid;
  logic out_stall;
  logic accepted;
  logic [tdpb_pkg::ARR_W-1:0] arrival_echo;

  tail_drop_scoreboard board;
  bit          hold_request;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned mode_cycles;
  int unsigned n_settings;

  tail_drop_packet_buffer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrival_time (arrival_time),
    .proc_time    (proc_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .arrival_echo (arrival_echo)
  );

  initial clk = 1'b0;
  always #(CLK_HALF_NS) clk = ~clk;

  // Offer one packet and hold it until the transfer happens.
  task automatic send_packet(input logic [tdpb_pkg::ARR_W-1:0] arrival,
                             input logic [tdpb_pkg::PROC_W-1:0] proc);
    in_valid <= 1'b1;
    arrival_time <= arrival;
    proc_time <= proc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_packet(arrival, proc);
  endtask

  // Drain outstanding results, then write the capacity register.
  task automatic write_capacity(input logic [tdpb_pkg::CFG_W-1:0] value);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    board.set_capacity(value);
    n_settings++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random bursts of packets with a time cursor that mostly advances.
  task automatic run_random_phase(input logic [tdpb_pkg::CFG_W-1:0] cap,
                                  input logic [tdpb_pkg::ARR_W-1:0] base,
                                  input bit long_hold);
    logic [tdpb_pkg::ARR_W-1:0]  cursor;
    logic [tdpb_pkg::ARR_W-1:0]  arrival;
    logic [tdpb_pkg::PROC_W-1:0] proc;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    int unsigned back;
    write_capacity(cap);
    if (long_hold) hold_request = 1'b1;
    cursor = base + $urandom_range(0, 1000);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          // late arrival, at or before the cursor
          back = $urandom_range(0, 50);
          arrival = (cursor > back) ? cursor - back : '0;
        end else if (pick < 6) begin
          cursor = cursor + $urandom_range(0, 1 << 17);
          arrival = cursor;
        end else begin
          cursor = cursor + $urandom_range(0, 30);
          arrival = cursor;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) proc = 16'($urandom);
        else if (pick < 8) proc = '0;
        else proc = 16'($urandom_range(1, 60));
        send_packet(arrival, proc);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 || sent == PHASE_ITEMS) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Check every result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(accepted, arrival_echo);
  end

  // Receiver: stall on a changing pattern, with one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_mode = 0;
    mode_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_cycles = $urandom_range(50, 200);
      end else begin
        mode_cycles--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [tdpb_pkg::CFG_W-1:0] caps[8];
    board = new();
    hold_request = 1'b0;
    n_settings = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    arrival_time = '0;
    proc_time = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // capacity from reset: tie on finish time, longest service time
    send_packet(32'd0, 16'd0);
    send_packet(32'd0, 16'd0);
    send_packet(32'd7, 16'hFFFF);
    send_packet(32'd8, 16'd1);
    send_packet(32'd65543, 16'd0);
    in_valid <= 1'b0;

    // small buffer: fill, drop, free on tie, late arrival
    write_capacity(5'd2);
    send_packet(32'd100000, 16'd10);
    send_packet(32'd100000, 16'd10);
    send_packet(32'd100000, 16'd10);
    send_packet(32'd100010, 16'd0);
    send_packet(32'd100005, 16'd1);
    in_valid <= 1'b0;

    // zero capacity drops everything
    write_capacity(5'd0);
    send_packet(32'd200000, 16'd5);
    in_valid <= 1'b0;

    // single slot
    write_capacity(5'd1);
    send_packet(32'd300000, 16'd3);
    send_packet(32'd300002, 16'd1);
    send_packet(32'd300003, 16'd1);
    in_valid <= 1'b0;

    // random phases across capacity settings, each in a higher time window
    caps = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd8, 5'd3, 5'd17, 5'd5};
    for (int p = 0; p < 8; p++) begin
      run_random_phase(caps[p], (p + 0) << 29, p == 1);
    end

    // top of the time range: saturating finish, late arrival after saturation
    write_capacity(5'd16);
    send_packet(32'hFFFF_FFF0, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 16'd5);
    send_packet(32'd0, 16'd1);
    send_packet(32'hFFFF_FFFF, 16'd0);
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d packets over %0d capacity settings: %0d queued, %0d dropped.",
             board.n_queued + board.n_dropped, n_settings, board.n_queued, board.n_dropped);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[tail_drop_packet_buffer] OK");
    end else begin
      $display("[tail_drop_packet_buffer] ERROR");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[tail_drop_packet_buffer] ERROR");
    $finish;
  end

endmodule
